@@ hdl/olid_pkg.sv @@
// Shared types and constants for the ordered list insert/delete block.
package olid_pkg;

  localparam int unsigned CapacityDef = 16;

  // Field widths of the stream payloads.
  localparam int unsigned CmdW   = 3;
  localparam int unsigned TokenW = 16;
  localparam int unsigned PosW   = 8;
  localparam int unsigned StatW  = 2;
  localparam int unsigned IdxW   = 4;
  localparam int unsigned CntW   = 5;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_INSERT     = 3'd2,
    CMD_DELETE     = 3'd3,
    CMD_REPORT_REV = 3'd4
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    STATUS_DONE     = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_NOTFOUND = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_WR,
    ST_DEL_RD,
    ST_DEL_CMP,
    ST_SHF_RD,
    ST_SHF_WR,
    ST_RPT_RD,
    ST_RPT_LD
  } state_e;

endpackage

@@ hdl/ordered_list_insert_delete.sv @@
// Ordered token list with push, positional insert, delete and full list report.
//
// One command arrives as a transfer on the slave stream; the block then edits
// its list and sends the whole list, one transfer per entry, on the master
// stream, with tlast on the final one. An empty list gives a single transfer
// with list_empty set. s_axis_tready_o is high only while the sequencer is idle.
// All work goes through one storage array with a single write port and one
// registered read port, so every entry moved takes a read state and a write
// state: an insert moves the entries from the end down to its slot up by one,
// and a delete reads and compares entries from the front until it finds the
// token, then moves the later ones down by one to close the gap. The report
// reads each entry (last first for CMD_REPORT_REV) and loads it into the
// output register; a stall holds the output register and the sequencer waits
// on it. Reset empties the list at once (the fill count is cleared; the array
// keeps stale data that is never read) and drops any result not yet taken.
module ordered_list_insert_delete
  import olid_pkg::*;
#(
  parameter int unsigned CAPACITY = CapacityDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: cmd [2:0], token [18:3], position [26:19], zero [31:27]
  input  logic [31:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: status [1:0], entry_token [17:2], entry_index [21:18],
  // entry_count [26:22], list_empty [27], zero [31:28]
  output logic [31:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o
);

  localparam int unsigned AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned PW  = ((CW > PosW) ? CW : PosW) + 1;
  localparam logic [CW-1:0] FullCount = CW'(CAPACITY);

  state_e              state_q, state_d;
  logic [AW-1:0]       ptr_q, ptr_d;
  logic [AW-1:0]       at_q, at_d;
  logic [CW-1:0]       fill_q, fill_d;
  logic [TokenW-1:0]   tok_q, tok_d;
  status_e             status_q, status_d;
  logic                rev_q, rev_d;

  logic                out_valid_q, out_valid_d;
  logic                out_last_q, out_last_d;
  logic [27:0]         out_data_q, out_data_d;

  logic [TokenW-1:0]   mem [CAPACITY];
  logic [TokenW-1:0]   rd_data_q;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       wr_addr;
  logic [TokenW-1:0]   wr_data;
  logic                mem_we;

  logic                in_xfer;
  cmd_e                in_cmd;
  logic [TokenW-1:0]   in_tok;
  logic [PosW-1:0]     in_pos;
  logic [PW-1:0]       pos_w, fill_w;
  logic [AW-1:0]       at_calc;
  logic                is_full, is_empty;
  logic [CW-1:0]       fill_m1;
  logic                ptr_at_end;
  logic                shift_more;
  logic                out_free;
  logic                tok_match;

  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign in_cmd   = cmd_e'(s_axis_tdata_i[CmdW-1:0]);
  assign in_tok   = s_axis_tdata_i[CmdW +: TokenW];
  assign in_pos   = s_axis_tdata_i[CmdW+TokenW +: PosW];

  assign is_full    = (fill_q == FullCount);
  assign is_empty   = (fill_q == '0);
  assign fill_m1    = fill_q - CW'(1);
  assign ptr_at_end = (CW'(ptr_q) == fill_m1);
  assign shift_more = ((CW'(ptr_q) + CW'(1)) < fill_q);
  assign out_free   = !out_valid_q || m_axis_tready_i;
  assign tok_match  = (rd_data_q == tok_q);

  // Insert slot: one or less goes to the front, past the end goes to the back.
  assign pos_w  = PW'(in_pos);
  assign fill_w = PW'(fill_q);
  always_comb begin
    case (in_cmd)
      CMD_PUSH_FRONT: at_calc = '0;
      CMD_PUSH_BACK:  at_calc = AW'(fill_q);
      CMD_INSERT: begin
        if (pos_w <= PW'(1)) begin
          at_calc = '0;
        end else if ((pos_w - PW'(1)) > fill_w) begin
          at_calc = AW'(fill_q);
        end else begin
          at_calc = AW'(pos_w - PW'(1));
        end
      end
      default:        at_calc = '0;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
              state_d = is_full ? ST_RPT_RD : ST_INS_RD;
            end
            CMD_DELETE: state_d = is_empty ? ST_RPT_RD : ST_DEL_RD;
            default:    state_d = ST_RPT_RD;
          endcase
        end
      end
      ST_INS_RD:  state_d = (ptr_q == at_q) ? ST_RPT_RD : ST_INS_WR;
      ST_INS_WR:  state_d = ST_INS_RD;
      ST_DEL_RD:  state_d = ST_DEL_CMP;
      ST_DEL_CMP: begin
        if (tok_match) begin
          state_d = ST_SHF_RD;
        end else if (ptr_at_end) begin
          state_d = ST_RPT_RD;
        end else begin
          state_d = ST_DEL_RD;
        end
      end
      ST_SHF_RD:  state_d = shift_more ? ST_SHF_WR : ST_RPT_RD;
      ST_SHF_WR:  state_d = ST_SHF_RD;
      ST_RPT_RD:  state_d = ST_RPT_LD;
      ST_RPT_LD: begin
        if (out_free) begin
          state_d = (is_empty || ptr_at_end) ? ST_IDLE : ST_RPT_RD;
        end
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    ptr_d       = ptr_q;
    at_d        = at_q;
    fill_d      = fill_q;
    tok_d       = tok_q;
    status_d    = status_q;
    rev_d       = rev_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_last_d  = out_last_q;
    out_data_d  = out_data_q;
    mem_we      = 1'b0;
    wr_addr     = ptr_q;
    wr_data     = rd_data_q;
    rd_addr     = ptr_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          tok_d    = in_tok;
          at_d     = at_calc;
          rev_d    = 1'b0;
          status_d = STATUS_DONE;
          ptr_d    = '0;
          case (in_cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
              if (is_full) begin
                status_d = STATUS_FULL;
              end else begin
                ptr_d = AW'(fill_q);
              end
            end
            CMD_DELETE: begin
              if (is_empty) begin
                status_d = STATUS_NOTFOUND;
              end
            end
            CMD_REPORT_REV: rev_d = 1'b1;
            default: ;
          endcase
        end
      end
      ST_INS_RD: begin
        rd_addr = ptr_q - AW'(1);
        if (ptr_q == at_q) begin
          mem_we  = 1'b1;
          wr_addr = at_q;
          wr_data = tok_q;
          fill_d  = fill_q + CW'(1);
          ptr_d   = '0;
        end
      end
      ST_INS_WR: begin
        rd_addr = ptr_q - AW'(1);
        mem_we  = 1'b1;
        ptr_d   = ptr_q - AW'(1);
      end
      ST_DEL_CMP: begin
        if (!tok_match) begin
          if (ptr_at_end) begin
            status_d = STATUS_NOTFOUND;
            ptr_d    = '0;
          end else begin
            ptr_d = ptr_q + AW'(1);
          end
        end
      end
      ST_SHF_RD: begin
        rd_addr = ptr_q + AW'(1);
        if (!shift_more) begin
          fill_d = fill_m1;
          ptr_d  = '0;
        end
      end
      ST_SHF_WR: begin
        rd_addr = ptr_q + AW'(1);
        mem_we  = 1'b1;
        ptr_d   = ptr_q + AW'(1);
      end
      ST_RPT_RD, ST_RPT_LD: begin
        rd_addr = rev_q ? AW'(fill_m1 - CW'(ptr_q)) : ptr_q;
        if (state_q == ST_RPT_LD && out_free) begin
          out_valid_d = 1'b1;
          if (is_empty) begin
            out_data_d = {1'b1, CntW'(0), IdxW'(0), TokenW'(0), status_q};
            out_last_d = 1'b1;
          end else begin
            out_data_d = {1'b0, CntW'(fill_q), IdxW'(rd_addr), rd_data_q, status_q};
            out_last_d = ptr_at_end;
            ptr_d      = ptr_q + AW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    at_q       <= at_d;
    tok_q      <= tok_d;
    status_q   <= status_d;
    rev_q      <= rev_d;
    out_last_q <= out_last_d;
    out_data_q <= out_data_d;
  end

  // List storage: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, out_data_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule
